@@ hw/rtl/dq_pkg.sv @@
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int REQ_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_SIZE       = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_DATA  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_SIZE  = 3'd4
  } status_t;

  // RAM strobes for the single shared address
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // What the response stage needs to build the result
  typedef struct packed {
    status_t              status;
    logic                 has_data;
    logic [COUNT_W-1:0]   count;
  } rsp_meta_t;

endpackage

`default_nettype wire

@@ hw/rtl/dq_ram.sv @@
`default_nettype none

module dq_ram
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire mem_ctl_t              ctl,
  input  wire logic [AW-1:0]         addr,
  input  wire logic [WORD_WIDTH-1:0] wr_data,
  output logic      [WORD_WIDTH-1:0] rd_data
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/dq_ctrl.sv @@
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int SW        = CW + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [REQ_W-1:0]      req_type,
  input  wire logic [DATA_W-1:0]     push_value,
  output mem_ctl_t                   mem_ctl,
  output logic      [AW-1:0]         mem_addr,
  output logic      [WORD_WIDTH-1:0] mem_wr_data,
  output rsp_meta_t                  meta
);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  req_t          req;
  logic          full;
  logic          empty;
  logic          wr_req;
  logic          rd_req;

  // head + off modulo DEPTH; both operands stay below DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(pos) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return AW'(sum);
  endfunction

  assign req         = req_t'(req_type);
  assign full        = (count_r == CW'(DEPTH));
  assign empty       = (count_r == '0);
  assign mem_wr_data = WORD_WIDTH'(push_value);

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    mem_addr      = head_r;
    wr_req        = 1'b0;
    rd_req        = 1'b0;
    meta.status   = ST_OK;
    meta.has_data = 1'b0;
    unique case (req) inside
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          meta.status = ST_FULL;
        end else begin
          wr_req    = 1'b1;
          count_nxt = count_r + CW'(1);
          if (req == REQ_PUSH_FRONT) begin
            head_nxt = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
            mem_addr = head_nxt;
          end else begin
            mem_addr = ring_add(head_r, count_r);
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (empty) begin
          meta.status = ST_EMPTY;
        end else begin
          meta.status   = ST_DATA;
          meta.has_data = 1'b1;
          rd_req        = 1'b1;
          if (req == REQ_POP_FRONT || req == REQ_PEEK_FRONT) begin
            mem_addr = head_r;
          end else begin
            mem_addr = ring_add(head_r, count_r - CW'(1));
          end
          if (req == REQ_POP_FRONT) begin
            head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
            count_nxt = count_r - CW'(1);
          end else if (req == REQ_POP_BACK) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      REQ_SIZE: begin
        meta.status = ST_SIZE;
      end
      REQ_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        meta.status = ST_OK;
      end
    endcase
    meta.count    = COUNT_W'(count_nxt);
    mem_ctl.wr_en = accept && wr_req;
    mem_ctl.rd_en = accept && rd_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_head_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req == REQ_POP_FRONT && !empty |=> count_r == $past(count_r) - CW'(1))
    else $error("pop front did not decrement count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req == REQ_CLEAR |=> count_r == '0 && head_r == '0)
    else $error("clear left stale pointers");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// Path: an accepted request is registered in the read stage along with its RAM read,
//   then moves into the output register, from which the result is taken.
// Throughput: one request per cycle while in_stall is low; pointer and count update at accept,
//   the single-port entry RAM is read or written in the same cycle.
// Back-pressure on the response side stalls requests only when both the
//   read stage and the output register are occupied.
// Reset (synchronous, rst_n low): queue empty, head at zero, requests stalled; RAM not cleared.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [DATA_W-1:0]   in_push_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [DATA_W-1:0]   out_data_out,
  output logic      [COUNT_W-1:0]  out_count_out
);

  logic                  accept;
  mem_ctl_t              mem_ctl;
  logic [AW-1:0]         mem_addr;
  logic [WORD_WIDTH-1:0] mem_wr_data;
  logic [WORD_WIDTH-1:0] mem_rd_data;
  rsp_meta_t             meta;

  logic                  s1_valid_r, s1_valid_nxt;
  rsp_meta_t             s1_meta_r;
  logic                  s1_adv;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [DATA_W-1:0]     out_data_r;
  logic [COUNT_W-1:0]    out_count_r;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .push_value  (in_push_value),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .meta        (meta)
  );

  dq_ram #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk     (clk),
    .ctl     (mem_ctl),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // read stage moves on whenever the output register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (s1_valid_r && out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      out_status_r <= s1_meta_r.status;
      out_count_r  <= s1_meta_r.count;
      out_data_r   <= s1_meta_r.has_data ? DATA_W'(mem_rd_data) : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data_out  = out_data_r;
  assign out_count_out = out_count_r;

`ifndef SYNTHESIS
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA |-> out_data_out == '0)
    else $error("data present on a response without data");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("request stalled with a free pipeline");

  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("read stage did not move into a free output register");
`endif

endmodule

`default_nettype wire
